// ===== hdl/rftg_pkg.sv =====
package rftg_pkg;

	localparam int BUCKET_BITS = 12;
	localparam int WAYS = 4;

	localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
	localparam int GEN_SLOTS = NUM_BUCKETS * WAYS;
	localparam int NUM_GENS = 3;
	localparam int MEM_DEPTH = NUM_GENS * GEN_SLOTS;
	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam int KEY_W = 32;
	localparam int SLOT_W = KEY_W + 1;
	localparam int IVL_W = 16;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [1:0] GEN_PREV = 2'd0;
	localparam logic [1:0] GEN_CUR = 2'd1;
	localparam logic [1:0] GEN_NEXT = 2'd2;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_REPLAY = 2'd1,
		ST_WINDOW = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_PROBE,
		S_SWEEP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic func;
		logic [KEY_W-1:0] key_id;
		logic [15:0] bucket_hash;
		logic [IVL_W-1:0] stamp;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [IVL_W-1:0] interval_now;
	} out_beat_t;

	function automatic logic [1:0] phys_gen(input logic [1:0] rot, input logic [1:0] logical);
		logic [2:0] sum;
		logic [1:0] res;
		sum = {1'b0, rot} + {1'b0, logical};
		case (sum)
			3'd0, 3'd3: res = 2'd0;
			3'd1, 3'd4: res = 2'd1;
			3'd2: res = 2'd2;
			default: res = 2'd0;
		endcase
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] gen_base(input logic [1:0] gen);
		logic [ADDR_W-1:0] res;
		case (gen)
			2'd0: res = '0;
			2'd1: res = ADDR_W'(GEN_SLOTS);
			default: res = ADDR_W'(2 * GEN_SLOTS);
		endcase
		return res;
	endfunction

endpackage

// ===== hdl/replay_filter_three_generation_core.sv =====
// Replay filter over three interval generations (previous, current, next), each holding
// NUM_BUCKETS buckets of WAYS key slots in one single-port slot memory that reads and
// compares one slot per cycle. An insert beat probes its bucket way by way and stops at a
// matching key; with no match the key goes into the first free way, else the bucket is
// full. The next item is taken once the result beat has left. A tick beat clears the
// oldest generation's GEN_SLOTS slots (16384 with the default sizes) one slot per cycle,
// then rotates the generations and advances the interval; a tick at interval 65535 only
// reports. After reset all MEM_DEPTH slots (49152 by default) are cleared with item_stall
// high. Configuration writes are always taken and load the current interval at once.
module replay_filter_three_generation_core
	import rftg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [IVL_W-1:0]     cfg_wr_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  in_beat_t             item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output out_beat_t            result
);

	state_t state_q, state_d;
	status_t status_q, status_d;
	logic [IVL_W-1:0] cur_int_q, cur_d;
	logic [1:0] rot_q, rot_d;

	logic [KEY_W-1:0] key_q;
	logic [ADDR_W-1:0] base_q, bucket_off_q;
	logic [ADDR_W-1:0] clr_q, clr_d, clr_end_q;
	logic [WAY_W-1:0] way_q, way_d, cmp_way_q, free_way_q, free_way_d;
	logic cmp_v_q, free_v_q, free_v_d;
	logic load;

	logic [SLOT_W-1:0] mem [MEM_DEPTH];
	logic [SLOT_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] rd_addr, mem_waddr;
	logic [SLOT_W-1:0] mem_wdata;
	logic mem_we;

	logic [IVL_W:0] stamp_x, cur_x;
	logic in_win;
	logic [1:0] logical, gen_sel;
	logic hit, empty;

	always_comb begin
		stamp_x = {1'b0, item.stamp};
		cur_x = {1'b0, cur_int_q};
		in_win = (stamp_x + 1'b1 >= cur_x) && (stamp_x <= cur_x + 1'b1);
		if (item.stamp > cur_int_q) begin
			logical = GEN_NEXT;
		end else if (item.stamp < cur_int_q) begin
			logical = GEN_PREV;
		end else begin
			logical = GEN_CUR;
		end
		gen_sel = phys_gen(rot_q, logical);
	end

	assign hit = cmp_v_q && rd_data_q[KEY_W] && (rd_data_q[KEY_W-1:0] == key_q);
	assign empty = cmp_v_q && !rd_data_q[KEY_W];
	assign rd_addr = base_q + bucket_off_q + ADDR_W'(way_q);

	always_comb begin
		state_d = state_q;
		status_d = status_q;
		cur_d = cur_int_q;
		rot_d = rot_q;
		clr_d = clr_q;
		way_d = way_q;
		free_v_d = free_v_q;
		free_way_d = free_way_q;
		load = 1'b0;
		mem_we = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
				clr_d = clr_q + 1'b1;
				if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					load = 1'b1;
					way_d = '0;
					free_v_d = 1'b0;
					if (item.func == FUNC_TICK) begin
						if (cur_int_q == '1) begin
							status_d = ST_OK;
							state_d = S_OUT;
						end else begin
							clr_d = gen_base(rot_q);
							state_d = S_SWEEP;
						end
					end else if (!in_win) begin
						status_d = ST_WINDOW;
						state_d = S_OUT;
					end else begin
						state_d = S_PROBE;
					end
				end
			end
			S_PROBE: begin
				if (way_q != WAY_W'(WAYS - 1)) begin
					way_d = way_q + 1'b1;
				end
				if (cmp_v_q) begin
					if (hit) begin
						status_d = ST_REPLAY;
						state_d = S_OUT;
					end else begin
						if (empty && !free_v_q) begin
							free_v_d = 1'b1;
							free_way_d = cmp_way_q;
						end
						if (cmp_way_q == WAY_W'(WAYS - 1)) begin
							state_d = S_OUT;
							if (free_v_d) begin
								mem_we = 1'b1;
								mem_waddr = base_q + bucket_off_q + ADDR_W'(free_way_d);
								mem_wdata = {1'b1, key_q};
								status_d = ST_OK;
							end else begin
								status_d = ST_FULL;
							end
						end
					end
				end
			end
			S_SWEEP: begin
				mem_we = 1'b1;
				clr_d = clr_q + 1'b1;
				if (clr_q == clr_end_q) begin
					rot_d = phys_gen(rot_q, GEN_CUR);
					cur_d = cur_int_q + 1'b1;
					status_d = ST_OK;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!result_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cfg_wr_en) begin
			cur_d = cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			status_q <= ST_OK;
			cur_int_q <= '0;
			rot_q <= '0;
			clr_q <= '0;
			way_q <= '0;
			cmp_v_q <= 1'b0;
			free_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
			cur_int_q <= cur_d;
			rot_q <= rot_d;
			clr_q <= clr_d;
			way_q <= way_d;
			cmp_v_q <= (state_q == S_PROBE);
			free_v_q <= free_v_d;
		end
	end

	always_ff @(posedge clk) begin
		cmp_way_q <= way_q;
		free_way_q <= free_way_d;
		if (load) begin
			key_q <= item.key_id;
			base_q <= gen_base(gen_sel);
			bucket_off_q <= ADDR_W'(ADDR_W'(item.bucket_hash[BUCKET_BITS-1:0]) * ADDR_W'(WAYS));
			clr_end_q <= gen_base(rot_q) + ADDR_W'(GEN_SLOTS - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end else begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign item_stall = (state_q != S_IDLE);
	assign result_valid = (state_q == S_OUT);
	assign result.status = status_q;
	assign result.interval_now = cur_int_q;

`ifndef ASSERT_OFF
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rot_q != 2'd3)
		else $error("generation rotation left its range");

	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_INIT || state_q == S_PROBE || state_q == S_SWEEP))
		else $error("slot memory written outside a clear or probe");

	a_probe_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && state_d == S_OUT) |-> cmp_v_q)
		else $error("probe finished without a compared slot");

	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && state_d == S_OUT && !cfg_wr_en)
		|=> (cur_int_q == $past(cur_int_q) + 1'b1))
		else $error("tick did not advance the interval");
`endif

endmodule

// ===== test/replay_filter_three_generation_core_test.sv =====
`timescale 1ns / 1ps

module replay_filter_three_generation_core_test;
	import rftg_pkg::*;

	localparam int HASH_POOL = 5;
	localparam int KEY_POOL = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [IVL_W-1:0] cfg_wr_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_beat_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_beat_t result;

	bit [SLOT_W-1:0] slot_mem [NUM_GENS][NUM_BUCKETS][WAYS];
	logic [IVL_W-1:0] interval_model = '0;
	int unsigned rot_model = 0;
	out_beat_t verdict_q[$];
	int mismatch_count = 0;
	bit calm = 1'b0;
	logic [15:0] hash_pool [HASH_POOL];
	logic [KEY_W-1:0] key_pool [KEY_POOL];

	replay_filter_three_generation_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic out_beat_t replay_verdict(input in_beat_t b);
		out_beat_t r;
		status_t s;
		int unsigned cur;
		int unsigned st;
		int unsigned lg;
		int unsigned gen;
		int unsigned bkt;
		int free_way;
		bit found;
		cur = interval_model;
		s = ST_OK;
		if (b.func == FUNC_TICK) begin
			if (interval_model != 16'hFFFF) begin
				gen = rot_model;
				for (int i = 0; i < NUM_BUCKETS; i++)
					for (int w = 0; w < WAYS; w++)
						slot_mem[gen][i][w] = '0;
				rot_model = (rot_model + 1) % 3;
				interval_model = interval_model + 1'b1;
			end
		end else begin
			st = b.stamp;
			if (st + 1 < cur || st > cur + 1) begin
				s = ST_WINDOW;
			end else begin
				lg = (st > cur) ? 2 : ((st < cur) ? 0 : 1);
				gen = (rot_model + lg) % 3;
				bkt = b.bucket_hash & (NUM_BUCKETS - 1);
				free_way = -1;
				found = 1'b0;
				for (int w = 0; w < WAYS; w++) begin
					if (slot_mem[gen][bkt][w][KEY_W]) begin
						if (slot_mem[gen][bkt][w][KEY_W-1:0] == b.key_id)
							found = 1'b1;
					end else if (free_way < 0) begin
						free_way = w;
					end
				end
				if (found)
					s = ST_REPLAY;
				else if (free_way < 0)
					s = ST_FULL;
				else
					slot_mem[gen][bkt][free_way] = {1'b1, b.key_id};
			end
		end
		r.status = s;
		r.interval_now = interval_model;
		return r;
	endfunction

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: result beat with nothing expected: status %0d interval %0d",
					$time, result.status, result.interval_now);
				mismatch_count++;
			end else begin
				want = verdict_q.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, result.status);
					mismatch_count++;
				end
				if (result.interval_now !== want.interval_now) begin
					$display("%0t: interval_now expected %0d actual %0d",
						$time, want.interval_now, result.interval_now);
					mismatch_count++;
				end
			end
		end
		result_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
	end

	task automatic send_beat(input logic f, input logic [KEY_W-1:0] k,
			input logic [15:0] h, input logic [IVL_W-1:0] s);
		in_beat_t b;
		b.func = f;
		b.key_id = k;
		b.bucket_hash = h;
		b.stamp = s;
		while (!calm && $urandom_range(99) < 31) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= b;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		verdict_q.push_back(replay_verdict(b));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_start(input logic [IVL_W-1:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		interval_model = v;
	endtask

	task automatic test_window_edges();
		send_beat(FUNC_INSERT, 32'h1111_0000, 16'h0010, 16'd0);
		send_beat(FUNC_INSERT, 32'h1111_0001, 16'h0010, 16'd1);
		send_beat(FUNC_INSERT, 32'h1111_0002, 16'h0010, 16'hFFFF);
		send_beat(FUNC_INSERT, 32'h1111_0003, 16'h0010, 16'd2);
		write_start(16'hFFFF);
		send_beat(FUNC_INSERT, 32'h2222_0000, 16'hFFFF, 16'hFFFF);
		send_beat(FUNC_INSERT, 32'h2222_0001, 16'hFFFF, 16'hFFFE);
		send_beat(FUNC_INSERT, 32'h2222_0002, 16'hFFFF, 16'd0);
		send_beat(FUNC_INSERT, 32'h2222_0003, 16'hFFFF, 16'hFFFD);
		send_beat(FUNC_TICK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_replay_and_full();
		write_start(16'd100);
		send_beat(FUNC_INSERT, 32'h0000_0000, 16'h0123, 16'd100);
		send_beat(FUNC_INSERT, 32'h0000_0000, 16'hF123, 16'd100);
		send_beat(FUNC_INSERT, 32'hFFFF_FFFF, 16'h0123, 16'd100);
		send_beat(FUNC_INSERT, 32'h5A5A_A5A5, 16'hA123, 16'd100);
		send_beat(FUNC_INSERT, 32'hA5A5_5A5A, 16'h5123, 16'd100);
		send_beat(FUNC_INSERT, 32'h1234_5678, 16'h0123, 16'd100);
		send_beat(FUNC_INSERT, 32'hFFFF_FFFF, 16'h0123, 16'd100);
		send_beat(FUNC_INSERT, 32'h0000_0000, 16'h0123, 16'd101);
		send_beat(FUNC_INSERT, 32'h0000_0000, 16'h0123, 16'd99);
	endtask

	task automatic test_tick_rotation();
		send_beat(FUNC_TICK, 32'h0, 16'h0, 16'h0);
		send_beat(FUNC_INSERT, 32'h0000_0000, 16'h0123, 16'd100);
		send_beat(FUNC_INSERT, 32'h0000_0000, 16'h0123, 16'd101);
		send_beat(FUNC_INSERT, 32'h0000_0000, 16'h0123, 16'd99);
		write_start(16'hFFFE);
		send_beat(FUNC_TICK, 32'h0, 16'h0, 16'h0);
		send_beat(FUNC_INSERT, 32'h0000_0000, 16'h0123, 16'hFFFE);
	endtask

	task automatic test_random_traffic(input int n);
		logic [KEY_W-1:0] k;
		logic [15:0] h;
		logic [IVL_W-1:0] s;
		int roll;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 2) begin
				send_beat(FUNC_TICK, $urandom, 16'($urandom_range(16'hFFFF)),
					16'($urandom_range(16'hFFFF)));
			end else begin
				if ($urandom_range(99) < 70)
					k = key_pool[$urandom_range(KEY_POOL - 1)];
				else
					k = $urandom;
				if ($urandom_range(99) < 70)
					h = (16'($urandom_range(16'hFFFF)) & ~16'(NUM_BUCKETS - 1))
						| hash_pool[$urandom_range(HASH_POOL - 1)];
				else
					h = 16'($urandom_range(16'hFFFF));
				roll = $urandom_range(99);
				if (roll < 85)
					s = interval_model + 16'($urandom_range(2)) - 16'd1;
				else if (roll < 95)
					s = $urandom_range(1) ? interval_model + 16'd2 : interval_model - 16'd2;
				else
					s = 16'($urandom_range(16'hFFFF));
				send_beat(FUNC_INSERT, k, h, s);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < HASH_POOL; i++)
			hash_pool[i] = 16'($urandom_range(NUM_BUCKETS - 1));
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_window_edges();
		test_replay_and_full();
		test_tick_rotation();
		write_start(16'($urandom_range(16'hFFFF)));
		test_random_traffic(166);
		write_start(16'd0);
		test_random_traffic(166);
		write_start(16'hFFFF);
		calm = 1'b1;
		test_random_traffic(166);
		calm = 1'b0;
		write_start(16'hFFFE);
		test_random_traffic(166);
		write_start(16'($urandom_range(16'hFFFF)));
		test_random_traffic(166);
		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && verdict_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
